// ===== hdl/eight_bit_cpu_low_opcode_execute_core_macros.svh =====
// Assertion macros for the low-opcode execute core.
`ifndef EIGHT_BIT_CPU_LOW_OPCODE_EXECUTE_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_LOW_OPCODE_EXECUTE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("execute core check failed");
`define EBC_NEVER(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> !(b)) \
        else $error("execute core forbidden combination");
`else
`define EBC_ASSERT(lbl, prop)
`define EBC_NEVER(lbl, a, b)
`endif
`endif

// ===== hdl/ebc_pkg.sv =====
// Shared types, constants and functions of the low-opcode execute core.
package ebc_pkg;

    localparam int MEM_AW = 16;

    localparam logic [1:0] SEL_CLR = 2'd0;
    localparam logic [1:0] SEL_A0  = 2'd1;
    localparam logic [1:0] SEL_A1  = 2'd2;

    localparam logic [7:0] OP_SHLD = 8'h22;

    typedef struct packed {
        logic       clear_we;
        logic [1:0] mem_sel;
        logic       rd_en;
        logic       capture;
        logic       load_in;
        logic       commit;
        logic       wr2;
    } ebc_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_shld;
    } ebc_sts_t;

    function automatic logic [1:0] instr_len(input logic [7:0] op);
        logic [1:0] len;
        len = 2'd1;
        if (op < 8'h40) begin
            if (op[3:0] == 4'h1 || op == 8'h22 || op == 8'h2a || op == 8'h32 || op == 8'h3a)
                len = 2'd3;
            else if (op[2:0] == 3'd6)
                len = 2'd2;
        end else if (op >= 8'hc0) begin
            if (op[2:0] == 3'd6 || op == 8'hd3 || op == 8'hdb)
                len = 2'd2;
            else if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == 8'hc3 || op == 8'hcb
                     || op == 8'hcd || op == 8'hdd || op == 8'hed || op == 8'hfd)
                len = 2'd3;
        end
        return len;
    endfunction

endpackage

// ===== hdl/ebc_ctrl.sv =====
// Sequencer: memory clear after reset, then per-item access and commit steps.
module ebc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  ebc_pkg::ebc_sts_t sts,
    output ebc_pkg::ebc_cmd_t cmd
);
    import ebc_pkg::*;
`include "eight_bit_cpu_low_opcode_execute_core_macros.svh"

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_ACC1   = 3'd2;
    localparam logic [2:0] ST_ACC2   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;
    localparam logic [2:0] ST_WR2    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mem_sel = SEL_A0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                cmd.mem_sel  = SEL_CLR;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ACC1;
                end
            end
            ST_ACC1:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_ACC2;
            end
            ST_ACC2:
            begin
                cmd.mem_sel = SEL_A1;
                cmd.rd_en   = 1'b1;
                cmd.capture = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the output register can take the item
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = sts.is_shld ? ST_WR2 : ST_IDLE;
                end
            end
            ST_WR2:
            begin
                cmd.mem_sel = SEL_A1;
                cmd.wr2     = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `EBC_ASSERT(a_commit_shows, cmd.commit |=> out_valid_reg)
    `EBC_NEVER(a_clear_blocks, state_reg == ST_CLEAR, !in_stall)
    `EBC_ASSERT(a_wr2_after_commit, (state_reg == ST_WR2) |-> $past(cmd.commit) && $past(sts.is_shld))
    `EBC_NEVER(a_no_commit_when_full, cmd.commit, out_valid_reg && out_stall)

endmodule

// ===== hdl/ebc_dpath.sv =====
// Register file, flags, program counter, data memory and output register.
module ebc_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  ebc_pkg::ebc_cmd_t cmd,
    output ebc_pkg::ebc_sts_t sts,
    input  logic [7:0]        opcode,
    input  logic [7:0]        imm_low,
    input  logic [7:0]        imm_high,
    output logic [15:0]       next_pc_out,
    output logic [7:0]        acc_out,
    output logic [4:0]        flags_out,
    output logic [15:0]       bc_out,
    output logic [15:0]       de_out,
    output logic [15:0]       hl_out,
    output logic [15:0]       sp_out
);
    import ebc_pkg::*;

    logic [7:0]  mem [2**MEM_AW];
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [MEM_AW-1:0] a0, a1, mem_addr;
    logic [7:0]  mem_rd_reg, byte0_reg, mem_wdata;
    logic        mem_we;

    logic [7:0]  op_reg, lo_reg, hi_reg;
    logic [7:0]  a_reg, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [15:0] sp_reg, pc_reg;
    logic [4:0]  f_reg;

    logic [7:0]  a_next, b_next, c_next, d_next, e_next, h_next, l_next;
    logic [15:0] sp_next, pc_next;
    logic [4:0]  f_next;

    logic [15:0] bc, de, hl, imm16, rp_val, pw_val;
    logic [16:0] dad_sum;
    logic [1:0]  rp, pw_code;
    logic [2:0]  dst, src;
    logic [7:0]  src_val, dst_val, rw_val, res8, cwdata;
    logic        pw_en, rw_en, cwe, szap_en, ac_bit;

    assign bc    = {b_reg, c_reg};
    assign de    = {d_reg, e_reg};
    assign hl    = {h_reg, l_reg};
    assign imm16 = {hi_reg, lo_reg};
    assign rp    = op_reg[5:4];
    assign dst   = op_reg[5:3];
    assign src   = op_reg[2:0];

    function automatic logic [7:0] pick_r(input logic [2:0] code, input logic [7:0] b,
        input logic [7:0] c, input logic [7:0] d, input logic [7:0] e, input logic [7:0] h,
        input logic [7:0] l, input logic [7:0] m, input logic [7:0] a);
        logic [7:0] v;
        case (code)
            3'd0: v = b;
            3'd1: v = c;
            3'd2: v = d;
            3'd3: v = e;
            3'd4: v = h;
            3'd5: v = l;
            3'd6: v = m;
            default: v = a;
        endcase
        return v;
    endfunction

    always_comb
    begin
        case (rp)
            2'd0: rp_val = bc;
            2'd1: rp_val = de;
            2'd2: rp_val = hl;
            default: rp_val = sp_reg;
        endcase
    end

    // first memory address of the item
    always_comb
    begin
        if (op_reg == 8'h02 || op_reg == 8'h12 || op_reg == 8'h0a || op_reg == 8'h1a)
            a0 = rp_val[MEM_AW-1:0];
        else if (op_reg == 8'h22 || op_reg == 8'h2a || op_reg == 8'h32 || op_reg == 8'h3a)
            a0 = imm16[MEM_AW-1:0];
        else
            a0 = hl[MEM_AW-1:0];
    end
    assign a1 = a0 + {{(MEM_AW-1){1'b0}}, 1'b1};

    assign src_val = pick_r(src, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, byte0_reg, a_reg);
    assign dst_val = pick_r(dst, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, byte0_reg, a_reg);
    assign dad_sum = {1'b0, hl} + {1'b0, rp_val};

    // decode into one pair write, one byte write and the flag update
    always_comb
    begin
        pw_en   = 1'b0;
        pw_code = rp;
        pw_val  = imm16;
        rw_en   = 1'b0;
        rw_val  = lo_reg;
        cwe     = 1'b0;
        cwdata  = a_reg;
        szap_en = 1'b0;
        ac_bit  = 1'b0;
        res8    = dst_val;
        a_next  = a_reg;
        f_next  = f_reg;
        if (!op_reg[7] && !op_reg[6])
        begin
            case (op_reg[2:0])
                3'd1:
                begin
                    pw_en = 1'b1;
                    if (op_reg[3])
                    begin
                        pw_code   = 2'd2;
                        pw_val    = dad_sum[15:0];
                        f_next[0] = dad_sum[16];
                    end
                end
                3'd2:
                begin
                    case (op_reg[5:3])
                        3'd0, 3'd2, 3'd6: cwe = 1'b1;
                        3'd4:
                        begin
                            cwe    = 1'b1;
                            cwdata = l_reg;
                        end
                        3'd5:
                        begin
                            pw_en   = 1'b1;
                            pw_code = 2'd2;
                            pw_val  = {mem_rd_reg, byte0_reg};
                        end
                        default: a_next = byte0_reg;
                    endcase
                end
                3'd3:
                begin
                    pw_en  = 1'b1;
                    pw_val = op_reg[3] ? rp_val - 16'd1 : rp_val + 16'd1;
                end
                3'd4:
                begin
                    res8    = dst_val + 8'd1;
                    rw_en   = 1'b1;
                    rw_val  = res8;
                    szap_en = 1'b1;
                    ac_bit  = (dst_val[3:0] == 4'hf);
                end
                3'd5:
                begin
                    res8    = dst_val - 8'd1;
                    rw_en   = 1'b1;
                    rw_val  = res8;
                    szap_en = 1'b1;
                    ac_bit  = (dst_val[3:0] != 4'h0);
                end
                3'd6:
                begin
                    rw_en  = 1'b1;
                    rw_val = lo_reg;
                end
                3'd7:
                begin
                    case (dst)
                        3'd0:
                        begin
                            a_next    = {a_reg[6:0], a_reg[7]};
                            f_next[0] = a_reg[7];
                        end
                        3'd1:
                        begin
                            a_next    = {a_reg[0], a_reg[7:1]};
                            f_next[0] = a_reg[0];
                        end
                        3'd2:
                        begin
                            a_next    = {a_reg[6:0], f_reg[0]};
                            f_next[0] = a_reg[7];
                        end
                        3'd3:
                        begin
                            a_next    = {f_reg[0], a_reg[7:1]};
                            f_next[0] = a_reg[0];
                        end
                        3'd5: a_next = ~a_reg;
                        3'd6: f_next[0] = 1'b1;
                        3'd7: f_next[0] = ~f_reg[0];
                        default: a_next = a_reg;
                    endcase
                end
                default: pw_en = 1'b0;
            endcase
        end
        else if (!op_reg[7] && op_reg != 8'h76)
        begin
            rw_en  = 1'b1;
            rw_val = src_val;
        end
        if (szap_en)
            f_next = {res8[7], res8 == 8'h00, ac_bit, ~^res8, f_reg[0]};
        if (rw_en && dst == 3'd6)
        begin
            cwe    = 1'b1;
            cwdata = rw_val;
        end
        if (rw_en && dst == 3'd7)
            a_next = rw_val;
    end

    always_comb
    begin
        b_next  = b_reg;
        c_next  = c_reg;
        d_next  = d_reg;
        e_next  = e_reg;
        h_next  = h_reg;
        l_next  = l_reg;
        sp_next = sp_reg;
        if (pw_en)
        begin
            case (pw_code)
                2'd0: {b_next, c_next} = pw_val;
                2'd1: {d_next, e_next} = pw_val;
                2'd2: {h_next, l_next} = pw_val;
                default: sp_next = pw_val;
            endcase
        end
        if (rw_en)
        begin
            case (dst)
                3'd0: b_next = rw_val;
                3'd1: c_next = rw_val;
                3'd2: d_next = rw_val;
                3'd3: e_next = rw_val;
                3'd4: h_next = rw_val;
                3'd5: l_next = rw_val;
                default: b_next = b_reg;
            endcase
        end
        pc_next = pc_reg + {14'd0, instr_len(op_reg)};
    end

    // single memory port
    always_comb
    begin
        case (cmd.mem_sel)
            SEL_CLR: mem_addr = clr_cnt_reg;
            SEL_A1:  mem_addr = a1;
            default: mem_addr = a0;
        endcase
        mem_we = cmd.clear_we || cmd.wr2 || (cmd.commit && cwe);
        if (cmd.clear_we)
            mem_wdata = 8'h00;
        else if (cmd.wr2)
            mem_wdata = h_reg;
        else
            mem_wdata = cwdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.rd_en)
            mem_rd_reg <= mem[mem_addr];
    end

    assign sts.clr_last = &clr_cnt_reg;
    assign sts.is_shld  = (op_reg == OP_SHLD);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= opcode;
            lo_reg <= imm_low;
            hi_reg <= imm_high;
        end
        if (cmd.capture)
            byte0_reg <= mem_rd_reg;
        if (cmd.commit)
        begin
            next_pc_out <= pc_next;
            acc_out     <= a_next;
            flags_out   <= f_next;
            bc_out      <= {b_next, c_next};
            de_out      <= {d_next, e_next};
            hl_out      <= {h_next, l_next};
            sp_out      <= sp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            a_reg  <= 8'h00;
            b_reg  <= 8'h00;
            c_reg  <= 8'h00;
            d_reg  <= 8'h00;
            e_reg  <= 8'h00;
            h_reg  <= 8'h00;
            l_reg  <= 8'h00;
            sp_reg <= 16'h0000;
            pc_reg <= 16'h0000;
            f_reg  <= 5'h00;
        end
        else
        begin
            if (cmd.clear_we)
                clr_cnt_reg <= clr_cnt_reg + {{(MEM_AW-1){1'b0}}, 1'b1};
            if (cmd.commit)
            begin
                a_reg  <= a_next;
                b_reg  <= b_next;
                c_reg  <= c_next;
                d_reg  <= d_next;
                e_reg  <= e_next;
                h_reg  <= h_next;
                l_reg  <= l_next;
                sp_reg <= sp_next;
                pc_reg <= pc_next;
                f_reg  <= f_next;
            end
        end
    end

endmodule

// ===== hdl/eight_bit_cpu_low_opcode_execute_core.sv =====
// Top level of the low-opcode execute core.
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, opcode, imm_low/high  | item in
//  out     | out_valid, out_stall, next_pc_out .. sp_out | item out
// An item is accepted in IDLE, read in ACC1 and ACC2 and registered as the result
// in COMMIT; the next item can be accepted once back in IDLE. SHLD adds a WR2
// step, its second byte write using the single data memory port once more.
// After reset the 65536-byte data memory is cleared, one byte per cycle,
// so no item is accepted until the clear has finished.
// A stalled output holds the sequencer before commit; no item is accepted
// until the previous one has committed and, for SHLD, written its second byte.
module eight_bit_cpu_low_opcode_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  opcode,
    input  logic [7:0]  imm_low,
    input  logic [7:0]  imm_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] next_pc_out,
    output logic [7:0]  acc_out,
    output logic [4:0]  flags_out,
    output logic [15:0] bc_out,
    output logic [15:0] de_out,
    output logic [15:0] hl_out,
    output logic [15:0] sp_out
);
    import ebc_pkg::*;

    ebc_cmd_t cmd;
    ebc_sts_t sts;

    ebc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ebc_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .opcode      (opcode),
        .imm_low     (imm_low),
        .imm_high    (imm_high),
        .next_pc_out (next_pc_out),
        .acc_out     (acc_out),
        .flags_out   (flags_out),
        .bc_out      (bc_out),
        .de_out      (de_out),
        .hl_out      (hl_out),
        .sp_out      (sp_out)
    );

endmodule

// ===== verif/eight_bit_cpu_low_opcode_execute_core_test.sv =====
// Testbench of the low-opcode execute core: predicts and checks every executed instruction.
module eight_bit_cpu_low_opcode_execute_core_test;

    localparam logic [7:0] OP_NOP  = 8'h00;
    localparam logic [7:0] OP_LXIB = 8'h01;
    localparam logic [7:0] OP_LXIH = 8'h21;
    localparam logic [7:0] OP_LXIS = 8'h31;
    localparam logic [7:0] OP_STAXB = 8'h02;
    localparam logic [7:0] OP_LDAXB = 8'h0a;
    localparam logic [7:0] OP_SHLD = 8'h22;
    localparam logic [7:0] OP_LHLD = 8'h2a;
    localparam logic [7:0] OP_STA  = 8'h32;
    localparam logic [7:0] OP_LDA  = 8'h3a;
    localparam logic [7:0] OP_MVIA = 8'h3e;
    localparam logic [7:0] OP_MVIM = 8'h36;
    localparam logic [7:0] OP_INRA = 8'h3c;
    localparam logic [7:0] OP_DCRA = 8'h3d;
    localparam logic [7:0] OP_INRM = 8'h34;
    localparam logic [7:0] OP_DCRM = 8'h35;
    localparam logic [7:0] OP_DADH = 8'h29;
    localparam logic [7:0] OP_DADS = 8'h39;
    localparam logic [7:0] OP_INXS = 8'h33;
    localparam logic [7:0] OP_DCXB = 8'h0b;
    localparam logic [7:0] OP_RLC  = 8'h07;
    localparam logic [7:0] OP_RRC  = 8'h0f;
    localparam logic [7:0] OP_RAL  = 8'h17;
    localparam logic [7:0] OP_RAR  = 8'h1f;
    localparam logic [7:0] OP_DAA  = 8'h27;
    localparam logic [7:0] OP_CMA  = 8'h2f;
    localparam logic [7:0] OP_STC  = 8'h37;
    localparam logic [7:0] OP_CMC  = 8'h3f;
    localparam logic [7:0] OP_MOVMA = 8'h77;
    localparam logic [7:0] OP_MOVAM = 8'h7e;
    localparam logic [7:0] OP_HLT  = 8'h76;
    localparam logic [7:0] OP_JMP  = 8'hc3;
    localparam logic [7:0] OP_LAST = 8'hff;
    localparam int LIMIT = 2000000;

    typedef struct packed {
        logic [15:0] pc;
        logic [7:0]  a;
        logic [4:0]  f;
        logic [15:0] bc, de, hl, sp;
    } cpu_view_t;

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
    logic [7:0] opcode, imm_low, imm_high;
    logic [15:0] next_pc_out, bc_out, de_out, hl_out, sp_out;
    logic [7:0] acc_out;
    logic [4:0] flags_out;

    eight_bit_cpu_low_opcode_execute_core u_top (.*);

    // predicted machine state
    logic [7:0]  m_a, m_b, m_c, m_d, m_e, m_h, m_l;
    logic [15:0] m_sp, m_pc;
    logic [4:0]  m_f;
    logic [7:0]  m_mem [logic [15:0]];
    cpu_view_t   expected_views [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          hold_cycles = 0;

    function automatic logic [7:0] mem_read(logic [15:0] adr);
        return m_mem.exists(adr) ? m_mem[adr] : 8'h00;
    endfunction

    function automatic logic [15:0] pair_of(logic [1:0] rp);
        case (rp)
            2'd0: return {m_b, m_c};
            2'd1: return {m_d, m_e};
            2'd2: return {m_h, m_l};
            default: return m_sp;
        endcase
    endfunction

    task automatic put_pair(logic [1:0] rp, logic [15:0] v);
        case (rp)
            2'd0: {m_b, m_c} = v;
            2'd1: {m_d, m_e} = v;
            2'd2: {m_h, m_l} = v;
            default: m_sp = v;
        endcase
    endtask

    function automatic logic [7:0] reg_of(logic [2:0] r);
        case (r)
            3'd0: return m_b;
            3'd1: return m_c;
            3'd2: return m_d;
            3'd3: return m_e;
            3'd4: return m_h;
            3'd5: return m_l;
            3'd6: return mem_read({m_h, m_l});
            default: return m_a;
        endcase
    endfunction

    task automatic put_reg(logic [2:0] r, logic [7:0] v);
        case (r)
            3'd0: m_b = v;
            3'd1: m_c = v;
            3'd2: m_d = v;
            3'd3: m_e = v;
            3'd4: m_h = v;
            3'd5: m_l = v;
            3'd6: m_mem[{m_h, m_l}] = v;
            default: m_a = v;
        endcase
    endtask

    task automatic set_szap(logic [7:0] r, logic ac);
        m_f = {r[7], r == 8'h00, ac, ~^r, m_f[0]};
    endtask

    function automatic logic [1:0] length_of(logic [7:0] op);
        if (op < 8'h40) begin
            if (op[3:0] == 4'h1 || op == OP_SHLD || op == OP_LHLD || op == OP_STA
                || op == OP_LDA)
                return 2'd3;
            if (op[2:0] == 3'd6) return 2'd2;
            return 2'd1;
        end
        if (op < 8'hc0) return 2'd1;
        if (op[2:0] == 3'd6 || op == 8'hd3 || op == 8'hdb) return 2'd2;
        if (op[2:0] == 3'd2 || op[2:0] == 3'd4 || op == OP_JMP || op == 8'hcb
            || op == 8'hcd || op == 8'hdd || op == 8'hed || op == 8'hfd)
            return 2'd3;
        return 2'd1;
    endfunction

    task automatic execute_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi);
        logic [15:0] imm;
        logic [16:0] sum;
        logic [1:0]  rp;
        logic [2:0]  dst;
        logic [7:0]  v;
        logic        cy;
        imm = {hi, lo};
        rp = op[5:4];
        dst = op[5:3];
        cy = m_f[0];
        if (op < 8'h40) begin
            case (op[2:0])
                3'd1:
                    if (op[3]) begin
                        sum = {1'b0, m_h, m_l} + {1'b0, pair_of(rp)};
                        {m_h, m_l} = sum[15:0];
                        m_f[0] = sum[16];
                    end else
                        put_pair(rp, imm);
                3'd2:
                    case (op)
                        OP_SHLD: begin
                            m_mem[imm] = m_l;
                            m_mem[imm + 16'd1] = m_h;
                        end
                        OP_LHLD: begin
                            m_l = mem_read(imm);
                            m_h = mem_read(imm + 16'd1);
                        end
                        OP_STA: m_mem[imm] = m_a;
                        OP_LDA: m_a = mem_read(imm);
                        default:
                            if (op[3]) m_a = mem_read(pair_of(rp));
                            else m_mem[pair_of(rp)] = m_a;
                    endcase
                3'd3: put_pair(rp, op[3] ? pair_of(rp) - 16'd1 : pair_of(rp) + 16'd1);
                3'd4: begin
                    v = reg_of(dst);
                    put_reg(dst, v + 8'd1);
                    set_szap(v + 8'd1, v[3:0] == 4'hf);
                end
                3'd5: begin
                    v = reg_of(dst);
                    put_reg(dst, v - 8'd1);
                    set_szap(v - 8'd1, v[3:0] != 4'h0);
                end
                3'd6: put_reg(dst, lo);
                3'd7:
                    case (dst)
                        3'd0: begin m_f[0] = m_a[7]; m_a = {m_a[6:0], m_a[7]}; end
                        3'd1: begin m_f[0] = m_a[0]; m_a = {m_a[0], m_a[7:1]}; end
                        3'd2: begin m_f[0] = m_a[7]; m_a = {m_a[6:0], cy}; end
                        3'd3: begin m_f[0] = m_a[0]; m_a = {cy, m_a[7:1]}; end
                        3'd5: m_a = ~m_a;
                        3'd6: m_f[0] = 1'b1;
                        3'd7: m_f[0] = ~cy;
                        default: ;
                    endcase
                default: ;
            endcase
        end else if (op < 8'h80 && op != OP_HLT)
            put_reg(dst, reg_of(op[2:0]));
        m_pc = m_pc + 16'(length_of(op));
        expected_views.push_back({m_pc, m_a, m_f, {m_b, m_c}, {m_d, m_e}, {m_h, m_l}, m_sp});
    endtask

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("[eight_bit_cpu_low_opcode_execute_core] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, now and then a long hold
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_cycles <= $urandom_range(10, 40);
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 3) == 0)
            out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 1) == 1);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        cpu_view_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_views.size() == 0) begin
                $error("result with no instruction pending");
                fail_count++;
            end else begin
                want = expected_views.pop_front();
                if (next_pc_out !== want.pc) begin
                    $error("next_pc_out exp %h got %h", want.pc, next_pc_out); fail_count++;
                end
                if (acc_out !== want.a) begin
                    $error("acc_out exp %h got %h", want.a, acc_out); fail_count++;
                end
                if (flags_out !== want.f) begin
                    $error("flags_out exp %h got %h", want.f, flags_out); fail_count++;
                end
                if (bc_out !== want.bc) begin
                    $error("bc_out exp %h got %h", want.bc, bc_out); fail_count++;
                end
                if (de_out !== want.de) begin
                    $error("de_out exp %h got %h", want.de, de_out); fail_count++;
                end
                if (hl_out !== want.hl) begin
                    $error("hl_out exp %h got %h", want.hl, hl_out); fail_count++;
                end
                if (sp_out !== want.sp) begin
                    $error("sp_out exp %h got %h", want.sp, sp_out); fail_count++;
                end
            end
        end
    end

    // valid stays high after acceptance; the next gap or a drain drops it
    task automatic send_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                                         : $urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) gap = 0;
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        imm_low <= lo;
        imm_high <= hi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        execute_instr(op, lo, hi);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_views.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_instr(OP_LXIB, 8'hff, 8'hff);
        send_instr(OP_LXIH, 8'hff, 8'hff);
        send_instr(OP_DADH, 8'h00, 8'h00);
        send_instr(OP_LXIS, 8'h00, 8'h80);
        send_instr(OP_DADS, 8'h00, 8'h00);
        send_instr(OP_SHLD, 8'hff, 8'hff);
        send_instr(OP_LHLD, 8'hfe, 8'hff);
        send_instr(OP_MVIA, 8'h0f, 8'h55);
        send_instr(OP_INRA, 8'h00, 8'h00);
        send_instr(OP_MVIA, 8'h00, 8'h00);
        send_instr(OP_DCRA, 8'h00, 8'h00);
        send_instr(OP_STA, 8'h34, 8'h12);
        send_instr(OP_LDA, 8'h00, 8'h00);
        send_instr(OP_MVIM, 8'h7f, 8'h00);
        send_instr(OP_INRM, 8'h00, 8'h00);
        send_instr(OP_DCRM, 8'h00, 8'h00);
        send_instr(OP_MOVAM, 8'h00, 8'h00);
        send_instr(OP_RLC, 8'h00, 8'h00);
        send_instr(OP_RRC, 8'h00, 8'h00);
        send_instr(OP_RAL, 8'h00, 8'h00);
        send_instr(OP_RAR, 8'h00, 8'h00);
        send_instr(OP_CMA, 8'h00, 8'h00);
        send_instr(OP_STC, 8'h00, 8'h00);
        send_instr(OP_CMC, 8'h00, 8'h00);
        send_instr(OP_DAA, 8'hff, 8'hff);
        send_instr(OP_HLT, 8'hff, 8'hff);
        send_instr(OP_JMP, 8'hff, 8'hff);
        send_instr(OP_LAST, 8'h00, 8'h00);
        send_instr(OP_NOP, 8'h00, 8'h00);
        send_instr(OP_STAXB, 8'h00, 8'h00);
        send_instr(OP_LDAXB, 8'h00, 8'h00);
        send_instr(OP_DCXB, 8'h00, 8'h00);
        send_instr(OP_INXS, 8'h00, 8'h00);
        send_instr(OP_MOVMA, 8'h00, 8'h00);
    endtask

    // keep addresses mostly in a small window so memory reads hit written bytes
    task automatic test_random(int count);
        logic [7:0] op, hi;
        repeat (count) begin
            op = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8'h7f));
            hi = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
            send_instr(op, 8'($urandom), hi);
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 200;
        repeat (8) send_instr(8'($urandom_range(0, 8'h7f)), 8'($urandom), 8'($urandom), 1);
        wait_drained();
        repeat (20) @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        opcode = 8'h00;
        imm_low = 8'h00;
        imm_high = 8'h00;
        {m_a, m_b, m_c, m_d, m_e, m_h, m_l} = '0;
        m_sp = '0;
        m_pc = '0;
        m_f = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(500);
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("[eight_bit_cpu_low_opcode_execute_core] OK");
        else
            $display("[eight_bit_cpu_low_opcode_execute_core] ERROR");
        $finish;
    end

endmodule
